// File: rtl/lap_pkg.sv
`default_nettype none

package lap_pkg;

  localparam int MAX_TAPS   = 24;
  localparam int HIST_DEPTH = MAX_TAPS + 1;
  localparam int LOOKAHEAD  = 5;
  localparam int IDX_W      = 5;

  // Arithmetic widths, sized for the largest filter length.
  localparam int SIG_W  = 24;
  localparam int GAIN_W = 32;
  localparam int ERR_W  = 25;
  localparam int PROD_W = 57;
  localparam int ACC_W  = 61;

  localparam int DIV_NUM_W = 66;
  localparam int DIV_DEN_W = 52;
  localparam int DIV_QUO_W = 33;
  localparam int DIV_CNT_W = 7;

  // Reciprocals for the two constant divisions of the smoothing step. The
  // reading term divides a value below 2^28 by 125 (product shifted by 35),
  // the feedback term a value below 2^26 by 5 (product shifted by 29); both
  // give the exact floor over those ranges.
  localparam logic [28:0] X_RECIP = 29'd274877907;
  localparam logic [26:0] V_RECIP = 27'd107374183;

  localparam logic [4:0] TAPS_RESET = 5'd5;

  // Datapath actions issued by the controller.
  localparam logic [3:0] ACT_NONE    = 4'd0;
  localparam logic [3:0] ACT_START_X = 4'd1;
  localparam logic [3:0] ACT_START_V = 4'd2;
  localparam logic [3:0] ACT_PUSH    = 4'd3;
  localparam logic [3:0] ACT_MU      = 4'd4;
  localparam logic [3:0] ACT_ERR     = 4'd5;
  localparam logic [3:0] ACT_MU_WR   = 4'd6;
  localparam logic [3:0] ACT_PRED_WR = 4'd7;
  localparam logic [3:0] ACT_OUT     = 4'd8;

  // Multiplier operand selections.
  localparam logic [2:0] MS_POW   = 3'd0;
  localparam logic [2:0] MS_EST   = 3'd1;
  localparam logic [2:0] MS_MUERR = 3'd2;
  localparam logic [2:0] MS_UPD   = 3'd3;
  localparam logic [2:0] MS_PRED  = 3'd4;

  typedef struct packed {
    logic [3:0]       act;
    logic             mul;
    logic [2:0]       msel;
    logic [IDX_W-1:0] idx;
    logic [2:0]       pidx;
    logic             acc_clr;
  } cmd_t;

  typedef struct packed {
    logic             div_busy;
    logic             adapt;
    logic             emit;
    logic             out_free;
    logic [IDX_W-1:0] taps_eff;
  } sts_t;

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    logic signed [23:0] r;
    if (x > 64'sd8388607) r = 24'sh7fffff;
    else if (x < -64'sd8388608) r = 24'sh800000;
    else r = x[23:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) r = 32'sh7fffffff;
    else if (x < -64'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/lap_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle. The numerator comes
// left-aligned; iters sets how many of its bits are consumed.
module lap_div (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  input  wire logic [lap_pkg::DIV_NUM_W-1:0]   num,
  input  wire logic [lap_pkg::DIV_DEN_W-1:0]   den,
  input  wire logic [lap_pkg::DIV_CNT_W-1:0]   iters,
  output logic                                 busy,
  output logic [lap_pkg::DIV_QUO_W-1:0]        quo
);

  logic [lap_pkg::DIV_NUM_W-1:0] num_sh;
  logic [lap_pkg::DIV_DEN_W-1:0] den_r;
  logic [lap_pkg::DIV_DEN_W-1:0] rem;
  logic [lap_pkg::DIV_CNT_W-1:0] cnt;
  logic [lap_pkg::DIV_DEN_W:0]   rem_sh;
  logic                          fits;

  assign rem_sh = {rem, num_sh[lap_pkg::DIV_NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= iters;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == 1) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quo    <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[lap_pkg::DIV_NUM_W-2:0], 1'b0};
      rem    <= fits ? lap_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_r})
                     : rem_sh[lap_pkg::DIV_DEN_W-1:0];
      quo    <= {quo[lap_pkg::DIV_QUO_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: rtl/lap_dp.sv
`default_nettype none

module lap_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire lap_pkg::cmd_t       cmd,
  output lap_pkg::sts_t            sts,
  input  wire logic [14:0]         stoch_sample,
  input  wire logic                cfg_valid,
  input  wire logic [4:0]          cfg_data,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic signed [23:0]       smoothed_value,
  output logic signed [23:0]       predict_two_ahead,
  output logic signed [23:0]       predict_five_ahead
);

  logic [4:0]                            taps;
  logic [lap_pkg::IDX_W-1:0]             taps_eff;
  logic [7:0]                            count;
  logic signed [23:0]                    hist [lap_pkg::HIST_DEPTH];
  logic signed [31:0]                    gain [lap_pkg::HIST_DEPTH];
  logic signed [23:0]                    pred [lap_pkg::LOOKAHEAD];
  logic signed [31:0]                    step;
  logic                                  mu_pending;
  logic                                  xneg;
  logic                                  vneg;
  logic [27:0]                           xnum;
  logic [25:0]                           vnum;
  logic signed [21:0]                    xval;
  logic signed [24:0]                    cterm;
  logic signed [23:0]                    vcur;
  logic signed [24:0]                    err;
  logic signed [31:0]                    upd;
  logic signed [lap_pkg::PROD_W-1:0]     prod;
  logic                                  prod_vld;
  logic [2:0]                            prod_sel;
  logic [lap_pkg::IDX_W-1:0]             prod_idx;
  logic signed [lap_pkg::ACC_W-1:0]      acc;

  logic [lap_pkg::IDX_W-1:0]             hidx;
  logic [lap_pkg::IDX_W-1:0]             gaddr;
  logic [2:0]                            pp_idx;
  logic                                  use_hist;
  logic signed [23:0]                    hist_rd;
  logic signed [31:0]                    gain_rd;
  logic signed [31:0]                    ma;
  logic signed [24:0]                    mb;
  logic signed [57:0]                    prod_sh;
  logic signed [lap_pkg::ACC_W-1:0]      acc_sh;
  logic signed [23:0]                    acc_sat;

  logic signed [16:0]                    ks;
  logic [14:0]                           kmag;
  logic [27:0]                           x_num;
  logic signed [24:0]                    h0n;
  logic [23:0]                           hmag;
  logic [25:0]                           v_num;
  logic [56:0]                           xprod;
  logic [52:0]                           vprod;
  logic [21:0]                           qx;
  logic [24:0]                           qv;
  logic signed [25:0]                    vsum;
  logic signed [23:0]                    vnew;
  logic [8:0]                            t5;

  logic                                  div_start;
  logic [lap_pkg::DIV_NUM_W-1:0]         div_num;
  logic [lap_pkg::DIV_DEN_W-1:0]         div_den;
  logic [lap_pkg::DIV_CNT_W-1:0]         div_iters;
  logic                                  div_busy;
  logic [lap_pkg::DIV_QUO_W-1:0]         div_quo;

  always_comb begin
    if (taps == 5'd0) taps_eff = 5'd1;
    else if (taps > 5'(lap_pkg::MAX_TAPS)) taps_eff = 5'(lap_pkg::MAX_TAPS);
    else taps_eff = taps;
  end

  assign t5 = {2'b00, taps_eff, 2'b00} + {4'b0000, taps_eff};

  assign sts.div_busy = div_busy;
  assign sts.adapt    = count >= {3'b000, taps_eff};
  assign sts.emit     = {count, 1'b0} >= t5;
  assign sts.out_free = !out_valid || !out_stall;
  assign sts.taps_eff = taps_eff;

  // Operand fetch. During prediction, steps that reach back past the
  // present read the history; later ones read the scratch predictions.
  always_comb begin
    use_hist = cmd.idx > {2'b00, cmd.pidx};
    hidx     = (cmd.msel == lap_pkg::MS_PRED) ? cmd.idx - {2'b00, cmd.pidx} - 5'd1
                                              : cmd.idx;
    pp_idx   = cmd.pidx - cmd.idx[2:0];
    gaddr    = (prod_vld && prod_sel == lap_pkg::MS_UPD) ? prod_idx : cmd.idx;
    hist_rd  = hist[hidx];
    gain_rd  = gain[gaddr];
  end

  always_comb begin
    case (cmd.msel)
      lap_pkg::MS_POW: begin
        ma = {{8{hist_rd[23]}}, hist_rd};
        mb = {hist_rd[23], hist_rd};
      end
      lap_pkg::MS_EST: begin
        ma = gain_rd;
        mb = {hist_rd[23], hist_rd};
      end
      lap_pkg::MS_MUERR: begin
        ma = step;
        mb = err;
      end
      lap_pkg::MS_UPD: begin
        ma = upd;
        mb = {hist_rd[23], hist_rd};
      end
      lap_pkg::MS_PRED: begin
        ma = gain_rd;
        mb = use_hist ? {hist_rd[23], hist_rd} : {pred[pp_idx][23], pred[pp_idx]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_sh = ($signed({prod[lap_pkg::PROD_W-1], prod}) + 58'sd2097152) >>> 22;
  assign acc_sh  = (acc + 61'sd4194304) >>> 23;
  assign acc_sat = lap_pkg::sat24($signed({{3{acc_sh[60]}}, acc_sh}));

  // Scaling of the input and of the previous value for the smoothing step.
  // Both divisions are by constants and round to nearest with ties away from
  // zero: magnitudes are biased by half the divisor, then divided by a
  // reciprocal multiplication in the cycle after.
  always_comb begin
    ks    = $signed({2'b00, stoch_sample}) - 17'sd12800;
    kmag  = ks[16] ? 15'(-ks) : ks[14:0];
    x_num = {kmag, 13'd0} + 28'd62;
    h0n   = -$signed({hist[0][23], hist[0]});
    hmag  = hist[0][23] ? h0n[23:0] : hist[0];
    v_num = {hmag, 2'b00} + 26'd2;
    xprod = xnum * lap_pkg::X_RECIP;
    vprod = vnum * lap_pkg::V_RECIP;
    qx    = xprod[56:35];
    qv    = {1'b0, vprod[52:29]};
    vsum  = $signed({{4{xval[21]}}, xval}) + $signed({cterm[24], cterm});
    vnew  = lap_pkg::sat24($signed({{38{vsum[25]}}, vsum}));
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = {1'b1, 65'd0};
    div_den   = {38'd0, acc[13:0]};
    div_iters = 7'd66;
    case (cmd.act)
      lap_pkg::ACT_MU: begin
        div_start = (acc != 0) && (acc[60:34] != 0);
        div_num   = {1'b1, 65'd0};
        div_den   = acc[51:0];
        div_iters = 7'd66;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lap_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .iters (div_iters),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      taps       <= lap_pkg::TAPS_RESET;
      count      <= '0;
      step       <= '0;
      mu_pending <= 1'b0;
      prod_vld   <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < lap_pkg::HIST_DEPTH; i++) begin
        hist[i] <= '0;
        gain[i] <= '0;
      end
    end else begin
      if (cfg_valid) taps <= cfg_data;

      prod_vld <= cmd.mul;

      if (prod_vld && prod_sel == lap_pkg::MS_UPD) begin
        gain[prod_idx] <= lap_pkg::sat32($signed({{32{gain_rd[31]}}, gain_rd}) +
                                         $signed({{6{prod_sh[57]}}, prod_sh}));
      end

      // The result register is loaded only when it is free, and empties on
      // any cycle the receiver takes it.
      if (cmd.act == lap_pkg::ACT_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (cmd.act)
        lap_pkg::ACT_PUSH: begin
          for (int i = lap_pkg::HIST_DEPTH - 1; i > 0; i--) hist[i] <= hist[i-1];
          hist[0] <= vnew;
          if (count != 8'hff) count <= count + 8'd1;
        end
        lap_pkg::ACT_MU: begin
          if (acc == 0) begin
            mu_pending <= 1'b0;
          end else if (acc[60:34] == 0) begin
            step       <= 32'sh7fffffff;
            mu_pending <= 1'b0;
          end else begin
            mu_pending <= 1'b1;
          end
        end
        lap_pkg::ACT_MU_WR: begin
          if (mu_pending) begin
            step <= (div_quo > 33'd2147483647) ? 32'sh7fffffff : div_quo[31:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod     <= ma * mb;
      prod_sel <= cmd.msel;
      prod_idx <= cmd.idx;
    end

    if (cmd.acc_clr) begin
      acc <= '0;
    end else if (prod_vld && prod_sel != lap_pkg::MS_UPD && prod_sel != lap_pkg::MS_MUERR) begin
      acc <= acc + $signed({{4{prod[lap_pkg::PROD_W-1]}}, prod});
    end

    if (prod_vld && prod_sel == lap_pkg::MS_MUERR) begin
      upd <= lap_pkg::sat32($signed({{6{prod_sh[57]}}, prod_sh}));
    end

    case (cmd.act)
      lap_pkg::ACT_START_X: begin
        xneg <= ks[16];
        xnum <= x_num;
        vneg <= hist[0][23];
        vnum <= v_num;
      end
      lap_pkg::ACT_START_V: begin
        xval  <= xneg ? $signed(-qx) : $signed(qx);
        cterm <= vneg ? $signed(-qv) : $signed(qv);
      end
      lap_pkg::ACT_PUSH:    vcur <= vnew;
      lap_pkg::ACT_ERR:     err <= $signed({vcur[23], vcur}) - $signed({acc_sat[23], acc_sat});
      lap_pkg::ACT_PRED_WR: pred[cmd.pidx] <= acc_sat;
      lap_pkg::ACT_OUT: begin
        smoothed_value     <= vcur;
        predict_two_ahead  <= pred[1];
        predict_five_ahead <= pred[lap_pkg::LOOKAHEAD-1];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/lap_ctrl.sv
`default_nettype none

module lap_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire lap_pkg::sts_t   sts,
  output lap_pkg::cmd_t        cmd
);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_DIVX  = 5'd1;
  localparam logic [4:0] ST_DIVV  = 5'd2;
  localparam logic [4:0] ST_POW   = 5'd3;
  localparam logic [4:0] ST_POWD  = 5'd4;
  localparam logic [4:0] ST_MU    = 5'd5;
  localparam logic [4:0] ST_EST   = 5'd6;
  localparam logic [4:0] ST_ESTD  = 5'd7;
  localparam logic [4:0] ST_ERR   = 5'd8;
  localparam logic [4:0] ST_MUW   = 5'd9;
  localparam logic [4:0] ST_UMUL  = 5'd10;
  localparam logic [4:0] ST_UMD   = 5'd11;
  localparam logic [4:0] ST_UPD   = 5'd12;
  localparam logic [4:0] ST_UPDD  = 5'd13;
  localparam logic [4:0] ST_PRED  = 5'd14;
  localparam logic [4:0] ST_PREDD = 5'd15;
  localparam logic [4:0] ST_PWR   = 5'd16;
  localparam logic [4:0] ST_OUT   = 5'd17;

  logic [4:0]                state;
  logic [4:0]                state_next;
  logic [lap_pkg::IDX_W-1:0] cnt;
  logic [lap_pkg::IDX_W-1:0] cnt_next;
  logic [2:0]                step_p;
  logic [2:0]                step_p_next;
  logic                      emit;
  logic                      emit_next;
  logic [lap_pkg::IDX_W-1:0] t;

  assign t        = sts.taps_eff;
  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    step_p_next = step_p;
    emit_next   = emit;
    cmd         = '0;
    cmd.act     = lap_pkg::ACT_NONE;
    cmd.idx     = cnt;
    cmd.pidx    = step_p;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.act    = lap_pkg::ACT_START_X;
          state_next = ST_DIVX;
        end
      end
      ST_DIVX: begin
        cmd.act    = lap_pkg::ACT_START_V;
        state_next = ST_DIVV;
      end
      ST_DIVV: begin
        cmd.act     = lap_pkg::ACT_PUSH;
        cmd.acc_clr = 1'b1;
        emit_next   = sts.emit;
        cnt_next    = '0;
        state_next  = sts.adapt ? ST_POW : ST_IDLE;
      end
      ST_POW: begin
        cmd.mul  = 1'b1;
        cmd.msel = lap_pkg::MS_POW;
        if (cnt == t - 1'b1) state_next = ST_POWD;
        else cnt_next = cnt + 1'b1;
      end
      ST_POWD: state_next = ST_MU;
      ST_MU: begin
        cmd.act     = lap_pkg::ACT_MU;
        cmd.acc_clr = 1'b1;
        cnt_next    = 5'd1;
        state_next  = ST_EST;
      end
      ST_EST: begin
        cmd.mul  = 1'b1;
        cmd.msel = lap_pkg::MS_EST;
        if (cnt == t) state_next = ST_ESTD;
        else cnt_next = cnt + 1'b1;
      end
      ST_ESTD: state_next = ST_ERR;
      ST_ERR: begin
        cmd.act    = lap_pkg::ACT_ERR;
        state_next = ST_MUW;
      end
      ST_MUW: begin
        if (!sts.div_busy) begin
          cmd.act    = lap_pkg::ACT_MU_WR;
          state_next = ST_UMUL;
        end
      end
      ST_UMUL: begin
        cmd.mul    = 1'b1;
        cmd.msel   = lap_pkg::MS_MUERR;
        state_next = ST_UMD;
      end
      ST_UMD: begin
        cnt_next   = 5'd1;
        state_next = ST_UPD;
      end
      ST_UPD: begin
        cmd.mul  = 1'b1;
        cmd.msel = lap_pkg::MS_UPD;
        if (cnt == t) state_next = ST_UPDD;
        else cnt_next = cnt + 1'b1;
      end
      ST_UPDD: begin
        cmd.acc_clr = 1'b1;
        cnt_next    = 5'd1;
        step_p_next = '0;
        state_next  = ST_PRED;
      end
      ST_PRED: begin
        cmd.mul  = 1'b1;
        cmd.msel = lap_pkg::MS_PRED;
        if (cnt == t) state_next = ST_PREDD;
        else cnt_next = cnt + 1'b1;
      end
      ST_PREDD: state_next = ST_PWR;
      ST_PWR: begin
        cmd.act     = lap_pkg::ACT_PRED_WR;
        cmd.acc_clr = 1'b1;
        if (step_p == 3'(lap_pkg::LOOKAHEAD - 1)) begin
          state_next = emit ? ST_OUT : ST_IDLE;
        end else begin
          step_p_next = step_p + 3'd1;
          cnt_next    = 5'd1;
          state_next  = ST_PRED;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.act    = lap_pkg::ACT_OUT;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      step_p <= '0;
      emit   <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      step_p <= step_p_next;
      emit   <= emit_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lms_adaptive_predictor.sv
// Normalized LMS linear predictor on a smoothed stochastic reading.
// Input channel: in_valid/in_stall carries stoch_sample (percent * 256). A
// transfer happens when in_valid is high and in_stall is low; in_stall stays
// high while an item is being worked on, so one item is in flight at a time.
// Output channel: out_valid/out_stall carries smoothed_value and the two- and
// five-step predictions (signed Q1.22). A result sits in an output register;
// while the receiver stalls it holds, and the block still takes and works on
// the next item, waiting at its end only if the register is still full.
// Configuration: cfg_valid/cfg_ready writes taps (cfg_ready is always high);
// write it only while the block is idle.
// Sequence: an item before adaptation starts goes through the transfer,
// the reciprocal multiplication for the scaling, and a step that smooths
// and stores the value. An adapting item then runs the power, estimate, gain
// update and five prediction passes at one multiply per cycle, waiting for
// the step-size division unless the power is zero or too small for it. An
// item with a result takes one step more, plus any wait for a stalled result
// to leave. The next transfer can happen on the cycle after. Warm-up items
// produce no result. Reset clears history, gains, step size, item count and
// the output register, and sets taps to 5.
`default_nettype none

module lms_adaptive_predictor (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [14:0]        stoch_sample,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [23:0]      smoothed_value,
  output logic signed [23:0]      predict_two_ahead,
  output logic signed [23:0]      predict_five_ahead,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [4:0]         cfg_data
);

  lap_pkg::cmd_t cmd;
  lap_pkg::sts_t sts;

  // Configuration writes are always taken; the register lives in the datapath.
  assign cfg_ready = 1'b1;

  lap_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lap_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .stoch_sample       (stoch_sample),
    .cfg_valid          (cfg_valid && cfg_ready),
    .cfg_data           (cfg_data),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .smoothed_value     (smoothed_value),
    .predict_two_ahead  (predict_two_ahead),
    .predict_five_ahead (predict_five_ahead)
  );

endmodule

`default_nettype wire

// File: rtl/lap_chk.sv
`default_nettype none

module lap_chk (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic [14:0]        stoch_sample,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [23:0] smoothed_value,
  input wire logic signed [23:0] predict_two_ahead,
  input wire logic signed [23:0] predict_five_ahead,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready,
  input wire logic [4:0]         cfg_data
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(smoothed_value) &&
                                  $stable(predict_two_ahead) &&
                                  $stable(predict_five_ahead)))
    else $error("stalled result changed");

  // An accepted item keeps the input busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not busy after a transfer");

  // A new result is loaded only at the end of an item's work.
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while idle");

  // Reset leaves the block empty and ready for input.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("block not empty after reset");

endmodule

bind lms_adaptive_predictor lap_chk u_lap_chk (.*);

`default_nettype wire
